[hw/rtl/hsfd_pkg.sv]
// ----------------------------------------------------------------------------
// hsfd_pkg: shared types and constants of the humidity sensor frame decoder
// Field types, status codes and the CRC-8 byte step (poly 0x31, MSB first).
// ----------------------------------------------------------------------------
`default_nettype none

package hsfd_pkg;

  typedef logic        [15:0] word_t;
  typedef logic signed [14:0] temp_centi_t;
  typedef logic        [13:0] hum_centi_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_t;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // One byte through the CRC-8 register, eight shift steps unrolled.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hsfd_scale.sv]
// ----------------------------------------------------------------------------
// hsfd_scale: raw sensor words to fixed-point readings
// temp = floor(17500*w/65535) - 4500, hum = floor(10000*w/65535).
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_scale
  import hsfd_pkg::*;
(
  input  word_t       temp_word,
  input  word_t       hum_word,
  output temp_centi_t temp_centi,
  output hum_centi_t  hum_centi
);

  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;

  logic [30:0] temp_prod;
  logic [29:0] hum_prod;
  logic [31:0] temp_sum;
  logic [31:0] hum_sum;
  logic [15:0] temp_scaled;

  // Divide by 2^16-1: q = (p + (p >> 16) + 1) >> 16, exact for p < 2^32 - 1.
  assign temp_prod = {16'd0, TEMP_SPAN} * {15'd0, temp_word};
  assign hum_prod  = {16'd0, HUM_SPAN} * {14'd0, hum_word};

  assign temp_sum = {1'b0, temp_prod} + {17'd0, temp_prod[30:16]} + 32'd1;
  assign hum_sum  = {2'b0, hum_prod} + {18'd0, hum_prod[29:16]} + 32'd1;

  // Quotient is at most 17500, so the 16-bit difference stays in range.
  assign temp_scaled = {1'b0, temp_sum[30:16]} - TEMP_OFFSET;
  assign temp_centi  = temp_scaled[14:0];
  assign hum_centi   = hum_sum[29:16];

endmodule

`default_nettype wire

[hw/rtl/humidity_sensor_frame_decoder.sv]
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder: CRC check and scaling of sensor frames
// Six-byte frames in, one decoded measurement out per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one frame byte per transfer. A frame
//   is temp MSB, temp LSB, temp CRC, hum MSB, hum LSB, hum CRC. Assert
//   in_frame_start with the first byte; a start mid-frame drops the partial
//   frame. Without a start flag, the byte after a sixth byte opens a frame.
//   Output channel (out_valid / out_stall): one transfer per complete frame
//   with raw words, status (temp CRC error wins over hum CRC error) and the
//   scaled temperature and humidity in hundredths.
//   Throughput: one byte per cycle while in_stall is low. Latency: the
//   result is valid the cycle after the sixth byte's transfer; the scaling
//   is one constant multiply and a reciprocal add per word, between the word
//   registers and the result register.
//   Stall: a waiting result holds in the result register. Bytes 1..5 keep
//   flowing; only a sixth byte is stalled while the previous result waits.
//   Reset (rst_n low, synchronous): byte position 0, CRC 0xFF, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_frame_decoder
  import hsfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_frame_start,
  // decoded frame output
  output logic             out_valid,
  input  wire logic        out_stall,
  output temp_centi_t      out_temp_centi,
  output hum_centi_t       out_hum_centi,
  output word_t            out_temp_word,
  output word_t            out_hum_word,
  output logic [1:0]       out_status
);

  // Byte positions within a frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  word_t       temp_hold_r, temp_hold_nxt;
  word_t       hum_hold_r, hum_hold_nxt;
  logic        temp_ok_r, temp_ok_nxt;

  logic        out_valid_r, out_valid_nxt;
  temp_centi_t temp_centi_r;
  hum_centi_t  hum_centi_r;
  word_t       temp_word_r;
  word_t       hum_word_r;
  status_t     status_r, status_nxt;

  logic [2:0]  pos_eff;
  logic        last_byte;
  logic        in_xfer;
  logic        out_xfer;
  logic        emit;
  logic [7:0]  crc_step;
  temp_centi_t temp_centi_c;
  hum_centi_t  hum_centi_c;

  // Start flag or an unreachable position restarts the frame
  always_comb begin
    if (in_frame_start || !(pos_r inside {[POS_T_MSB:POS_H_CRC]})) begin
      pos_eff = POS_T_MSB;
    end else begin
      pos_eff = pos_r;
    end
  end

  assign last_byte = (pos_eff == POS_H_CRC);

  // Only a result-producing byte waits on a pending, stalled result
  assign in_stall = out_valid_r && out_stall && last_byte;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign emit     = in_xfer && last_byte;

  assign crc_step = crc8_byte((pos_eff == POS_T_MSB || pos_eff == POS_H_MSB) ? CRC_INIT : crc_r,
                              in_rx_byte);

  // Frame assembly
  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    temp_hold_nxt = temp_hold_r;
    hum_hold_nxt  = hum_hold_r;
    temp_ok_nxt   = temp_ok_r;
    status_nxt    = STATUS_OK;
    if (!temp_ok_r) begin
      status_nxt = STATUS_TEMP_CRC;
    end else if (crc_r != in_rx_byte) begin
      status_nxt = STATUS_HUM_CRC;
    end
    if (in_xfer) begin
      case (pos_eff)
        POS_T_MSB: begin
          crc_nxt       = crc_step;
          temp_hold_nxt = {in_rx_byte, 8'h00};
          pos_nxt       = POS_T_LSB;
        end
        POS_T_LSB: begin
          crc_nxt       = crc_step;
          temp_hold_nxt = {temp_hold_r[15:8], in_rx_byte};
          pos_nxt       = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_ok_nxt = (crc_r == in_rx_byte);
          crc_nxt     = CRC_INIT;
          pos_nxt     = POS_H_MSB;
        end
        POS_H_MSB: begin
          crc_nxt      = crc_step;
          hum_hold_nxt = {in_rx_byte, 8'h00};
          pos_nxt      = POS_H_LSB;
        end
        POS_H_LSB: begin
          crc_nxt      = crc_step;
          hum_hold_nxt = {hum_hold_r[15:8], in_rx_byte};
          pos_nxt      = POS_H_CRC;
        end
        default: begin
          // humidity CRC byte: result goes out, frame closes
          crc_nxt = CRC_INIT;
          pos_nxt = POS_T_MSB;
        end
      endcase
    end
  end

  // Scaling works straight off the assembled word registers
  hsfd_scale u_scale (
    .temp_word  (temp_hold_r),
    .hum_word   (hum_hold_r),
    .temp_centi (temp_centi_c),
    .hum_centi  (hum_centi_c)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_MSB;
      crc_r       <= CRC_INIT;
      temp_hold_r <= '0;
      hum_hold_r  <= '0;
      temp_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_hold_r <= temp_hold_nxt;
      hum_hold_r  <= hum_hold_nxt;
      temp_ok_r   <= temp_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register: loaded only when a frame completes
  always_ff @(posedge clk) begin
    if (emit) begin
      temp_centi_r <= temp_centi_c;
      hum_centi_r  <= hum_centi_c;
      temp_word_r  <= temp_hold_r;
      hum_word_r   <= hum_hold_r;
      status_r     <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_temp_centi = temp_centi_r;
  assign out_hum_centi  = hum_centi_r;
  assign out_temp_word  = temp_word_r;
  assign out_hum_word   = hum_word_r;
  assign out_status     = status_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_H_CRC)
    else $error("byte position out of range");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid)
    else $error("completed frame did not produce a result");

  a_rise_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pos_r) == POS_H_CRC || $past(in_frame_start) == 1'b0
                         && $past(pos_eff) == POS_H_CRC)
    else $error("result appeared without a sixth byte");

  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> pos_r == POS_T_MSB)
    else $error("byte position did not wrap after a frame");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no pending result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("invalid status code");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for humidity_sensor_frame_decoder
// Sends six-byte sensor frames (clean, CRC-corrupted, cut short and loose
// noise bytes) into the decoder. A scoreboard class decodes every accepted
// byte on its own and checks each decoded reading field by field, in order.
// The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------

module tb;
  import hsfd_pkg::*;

  // One decoded measurement, as the result channel presents it.
  typedef struct {
    temp_centi_t temp_centi;
    hum_centi_t  hum_centi;
    word_t       temp_word;
    word_t       hum_word;
    status_t     status;
  } reading_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks frame position and CRC for every accepted byte and
  // queues the reading that each sixth byte must produce.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [2:0]  pos;
    logic [7:0]  crc;
    word_t       temp_acc;
    bit          temp_good;
    word_t       hum_acc;
    reading_t    due_readings[$];
    int unsigned errors;

    function new();
      pos       = 3'd0;
      crc       = CRC_INIT;
      temp_acc  = '0;
      temp_good = 1'b0;
      hum_acc   = '0;
      errors    = 0;
    endfunction

    // CRC-8, one data bit fed at a time against the register MSB.
    static function logic [7:0] crc_feed(input logic [7:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ d[i];
        c  = {c[6:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    static function logic [7:0] word_crc(input word_t w);
      return crc_feed(crc_feed(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    function int readings_due();
      return due_readings.size();
    endfunction

    function void flag(input string what, input int want, input int got);
      errors++;
      if (errors <= 10) begin
        $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
      end
    endfunction

    // One accepted byte into the frame decoder model.
    function void decode_byte(input logic [7:0] b, input logic start);
      logic [2:0]  p;
      reading_t    r;
      int unsigned tq;
      int unsigned hq;
      int          tc;
      p = start ? 3'd0 : pos;
      if (p > 3'd5) begin
        p = 3'd0;
      end
      case (p)
        3'd0: begin
          crc      = crc_feed(CRC_INIT, b);
          temp_acc = {b, 8'h00};
          pos      = 3'd1;
        end
        3'd1: begin
          crc           = crc_feed(crc, b);
          temp_acc[7:0] = b;
          pos           = 3'd2;
        end
        3'd2: begin
          temp_good = (crc == b);
          crc       = CRC_INIT;
          pos       = 3'd3;
        end
        3'd3: begin
          crc     = crc_feed(CRC_INIT, b);
          hum_acc = {b, 8'h00};
          pos     = 3'd4;
        end
        3'd4: begin
          crc          = crc_feed(crc, b);
          hum_acc[7:0] = b;
          pos          = 3'd5;
        end
        default: begin
          // temperature error wins over humidity error
          if (!temp_good) begin
            r.status = STATUS_TEMP_CRC;
          end else if (crc != b) begin
            r.status = STATUS_HUM_CRC;
          end else begin
            r.status = STATUS_OK;
          end
          tq = (17500 * temp_acc) / 65535;
          hq = (10000 * hum_acc) / 65535;
          tc = int'(tq) - 4500;
          r.temp_centi = tc[14:0];
          r.hum_centi  = hq[13:0];
          r.temp_word  = temp_acc;
          r.hum_word   = hum_acc;
          due_readings.push_back(r);
          crc = CRC_INIT;
          pos = 3'd0;
        end
      endcase
    endfunction

    function void check_reading(input temp_centi_t tc, input hum_centi_t hc,
                                input word_t tw, input word_t hw, input logic [1:0] st);
      reading_t want;
      if (due_readings.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] reading with no frame pending", $realtime);
        end
        return;
      end
      want = due_readings.pop_front();
      if (tc !== want.temp_centi) flag("temp_centi", int'(want.temp_centi), int'(tc));
      if (hc !== want.hum_centi) flag("hum_centi", int'(want.hum_centi), int'(hc));
      if (tw !== want.temp_word) flag("temp_word", int'(want.temp_word), int'(tw));
      if (hw !== want.hum_word) flag("hum_word", int'(want.hum_word), int'(hw));
      if (st !== want.status) flag("status", int'(want.status), int'(st));
    endfunction

    function void close_out();
      if (due_readings.size() != 0) begin
        errors += due_readings.size();
        $display("%0d readings never arrived", due_readings.size());
      end
    endfunction
  endclass

  localparam int ITEMS      = 1600;
  localparam int CYCLE_CAP  = 200000;
  localparam int HOLD_LEN   = 240;

  // Clock and reset: 8 ns period, reset low at the start.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // Byte channel
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte     = 8'h00;
  logic        in_frame_start = 1'b0;
  // Reading channel
  logic        out_valid;
  logic        out_stall      = 1'b0;
  temp_centi_t out_temp_centi;
  hum_centi_t  out_hum_centi;
  word_t       out_temp_word;
  word_t       out_hum_word;
  logic [1:0]  out_status;

  frame_scoreboard sb;
  int  bytes_sent = 0;
  int  cycles     = 0;
  bit  calm       = 1'b0;  // no random idling on either side while set
  bit  hold_req   = 1'b0;  // asks the receiver for a long hold-off

  humidity_sensor_frame_decoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_temp_centi (out_temp_centi),
    .out_hum_centi  (out_hum_centi),
    .out_temp_word  (out_temp_word),
    .out_hum_word   (out_hum_word),
    .out_status     (out_status)
  );

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("FAIL humidity_sensor_frame_decoder");
      $finish;
    end
  end

  // Monitor. Values read at the edge are the ones the block saw, since all
  // drives here land as nonblocking updates after the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.decode_byte(in_rx_byte, in_frame_start);
      end
      if (out_valid && !out_stall) begin
        sb.check_reading(out_temp_centi, out_hum_centi, out_temp_word,
                         out_hum_word, out_status);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request. During the
  // hold-off the decoder keeps taking bytes until a sixth byte backs up.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 8);
      end
    end
  end

  // One byte transfer, with a random idle gap ahead of it. Payload holds
  // steady while the block stalls.
  task automatic push_byte(input logic [7:0] b, input logic start);
    int gap;
    if (!calm && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 4);
      in_valid       <= 1'b0;
      in_rx_byte     <= 8'($urandom);
      in_frame_start <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Full frame; a corrupted CRC is the good one with random bits flipped.
  task automatic push_frame(input word_t tw, input word_t hw, input bit bad_t,
                            input bit bad_h, input logic start);
    logic [7:0] tcrc;
    logic [7:0] hcrc;
    tcrc = frame_scoreboard::word_crc(tw);
    hcrc = frame_scoreboard::word_crc(hw);
    if (bad_t) tcrc ^= 8'($urandom_range(1, 255));
    if (bad_h) hcrc ^= 8'($urandom_range(1, 255));
    push_byte(tw[15:8], start);
    push_byte(tw[7:0], 1'b0);
    push_byte(tcrc, 1'b0);
    push_byte(hw[15:8], 1'b0);
    push_byte(hw[7:0], 1'b0);
    push_byte(hcrc, 1'b0);
  endtask

  // Word values lean toward the scaling corners now and then.
  function automatic word_t pick_word();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) return 16'h0000;
    if (sel < 8) return 16'hFFFF;
    if (sel < 10) return 16'h0001;
    if (sel < 12) return 16'hFFFE;
    if (sel < 14) return 16'h8000;
    if (sel < 16) return 16'h7FFF;
    return word_t'($urandom);
  endfunction

  initial begin : stimulus
    int  kind;
    int  n;
    bit  held;
    bit  drained;
    held    = 1'b0;
    drained = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Directed: scaling extremes with clean CRCs
    push_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    // both CRCs bad, and no start flag: position wraps into a new frame
    push_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0);
    // frame cut after two bytes by a fresh start; humidity CRC bad
    push_byte(8'h66, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_frame(16'h6666, 16'h8000, 1'b0, 1'b1, 1'b1);
    // temperature CRC bad only
    push_frame(16'h1234, 16'hABCD, 1'b1, 1'b0, 1'b1);

    // Random: mostly well-formed frames, some cut short, some loose noise
    while (bytes_sent < ITEMS) begin
      calm = (bytes_sent >= 700) && (bytes_sent < 1000);
      if (!held && bytes_sent >= 400) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!drained && bytes_sent >= 1100) begin
        // sender goes quiet until every reading is in, after waiting for
        // the monitor to log the last accepted byte
        drained = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.readings_due() != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        push_frame(pick_word(), pick_word(), $urandom_range(0, 99) < 10,
                   $urandom_range(0, 99) < 10, $urandom_range(0, 9) != 0);
      end else if (kind < 90) begin
        n = $urandom_range(1, 5);
        push_byte(8'($urandom), 1'b1);
        for (int i = 1; i < n; i++) push_byte(8'($urandom), 1'b0);
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'($urandom));
      end
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (sb.readings_due() != 0) @(posedge clk);
    // keep the clock running so a stray late reading is still caught
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("PASS humidity_sensor_frame_decoder");
    end else begin
      $display("FAIL humidity_sensor_frame_decoder");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/hsfd_pkg.sv
hw/rtl/hsfd_scale.sv
hw/rtl/humidity_sensor_frame_decoder.sv
tb/sv/tb.sv
